>>> hw/rtl/assert_macros.svh
// Assertion helpers; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/dsga_pkg.sv
package dsga_pkg;

  localparam int DSGA_DIMS  = 3;
  localparam int DSGA_AXES  = 3;
  localparam int AXW        = 2;
  localparam int SQRT_STEPS = 33;
  localparam int DIV_STEPS  = 64;
  localparam int CNTW       = 7;

  localparam logic [62:0] POT_MAX = {63{1'b1}};

  // work phases of the shared multiplier
  localparam logic [2:0] PH_SQ = 3'd0;
  localparam logic [2:0] PH_PU = 3'd1;
  localparam logic [2:0] PH_U  = 3'd2;
  localparam logic [2:0] PH_W  = 3'd3;
  localparam logic [2:0] PH_A  = 3'd4;

  typedef struct packed {
    logic           load;
    logic           mul_go;
    logic [1:0]     part;
    logic           wb;
    logic           sqrt_init;
    logic           sqrt_step;
    logic           div_init;
    logic           div_step;
    logic           emit;
    logic [2:0]     phase;
    logic [AXW-1:0] axis;
  } dsga_cmd_t;

  typedef struct packed {
    logic s_zero;
    logic last;
    logic out_busy;
  } dsga_sts_t;

endpackage

>>> hw/rtl/dsga_ctrl.sv
module dsga_ctrl #(
  parameter int DIMS = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  dsga_pkg::dsga_sts_t sts,
  output dsga_pkg::dsga_cmd_t cmd
);
  import dsga_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MUL   = 4'd1;
  localparam logic [3:0] ST_DRAIN = 4'd2;
  localparam logic [3:0] ST_WB    = 4'd3;
  localparam logic [3:0] ST_ZCHK  = 4'd4;
  localparam logic [3:0] ST_SQRT  = 4'd5;
  localparam logic [3:0] ST_DINIT = 4'd6;
  localparam logic [3:0] ST_DIV   = 4'd7;
  localparam logic [3:0] ST_EMIT  = 4'd8;

  localparam logic [AXW-1:0] AX_LAST = AXW'(DIMS - 1);

  logic [3:0]      state_r, state_nxt;
  logic [2:0]      phase_r, phase_nxt;
  logic [AXW-1:0]  axis_r, axis_nxt;
  logic [1:0]      part_r, part_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    axis_nxt  = axis_r;
    part_nxt  = part_r;
    cnt_nxt   = cnt_r;
    in_tready = 1'b0;
    cmd       = '0;
    cmd.phase = phase_r;
    cmd.axis  = axis_r;
    cmd.part  = part_r;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          phase_nxt = PH_SQ;
          axis_nxt  = '0;
          part_nxt  = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_go = 1'b1;
        part_nxt   = part_r + 2'd1;
        if (part_r == 2'd3) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_WB;
      ST_WB: begin
        cmd.wb    = 1'b1;
        part_nxt  = '0;
        state_nxt = ST_MUL;
        case (phase_r)
          PH_SQ: begin
            if (axis_r == AX_LAST) state_nxt = ST_ZCHK;
            else axis_nxt = axis_r + 1'b1;
          end
          PH_PU: begin
            axis_nxt  = '0;
            phase_nxt = PH_U;
          end
          PH_U: phase_nxt = PH_W;
          PH_W: phase_nxt = PH_A;
          PH_A: begin
            if (axis_r == AX_LAST) begin
              state_nxt = ST_EMIT;
            end else begin
              axis_nxt  = axis_r + 1'b1;
              phase_nxt = PH_U;
            end
          end
          default: state_nxt = ST_EMIT;
        endcase
      end
      ST_ZCHK: begin
        if (sts.s_zero) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd.sqrt_init = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CNTW'(SQRT_STEPS - 1)) state_nxt = ST_DINIT;
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNTW'(DIV_STEPS - 1)) begin
          phase_nxt = PH_PU;
          axis_nxt  = '0;
          part_nxt  = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_EMIT: begin
        // a last-flagged item holds until the output register is free; others go idle
        if (!sts.last) begin
          state_nxt = ST_IDLE;
        end else if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_SQ;
      axis_r  <= '0;
      part_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      axis_r  <= axis_nxt;
      part_r  <= part_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

>>> hw/rtl/dsga_datapath.sv
module dsga_datapath #(
  parameter int DIMS = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [223:0]        in_tdata,
  input  logic                in_tuser,
  input  logic                in_tlast,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [255:0]        out_tdata,
  input  dsga_pkg::dsga_cmd_t cmd,
  output dsga_pkg::dsga_sts_t sts
);
  import dsga_pkg::*;

  logic [32:0]        mag_r  [DSGA_AXES];
  logic               neg_r  [DSGA_AXES];
  logic signed [63:0] sum_r  [DSGA_AXES];
  logic [31:0]        mass_r;
  logic               last_r;
  logic [65:0]        s_r;
  logic [33:0]        rem_r;
  logic [32:0]        root_r;
  logic [32:0]        drem_r;
  logic [63:0]        inv_r;
  logic [63:0]        pu_r;
  logic [31:0]        u_r;
  logic [63:0]        w_r;
  logic [62:0]        pot_r;
  logic [63:0]        pp_r;
  logic [1:0]         sh_r;
  logic               pp_vld_r;
  logic [127:0]       prod_r;
  logic [255:0]       out_data_r;
  logic               out_valid_r;

  logic [63:0]        op_a, op_b;
  logic [31:0]        a_half, b_half;
  logic [35:0]        rem_sh, trial, rem_diff;
  logic [33:0]        dnum, ddiff;
  logic [63:0]        pu_new, headroom;
  logic [79:0]        a_big;
  logic               a_ovf;
  logic signed [63:0] term;
  logic signed [64:0] sum_ext;
  logic signed [63:0] sum_sat;

  // operand select for the shared multiplier
  always_comb begin
    case (cmd.phase)
      PH_SQ: begin
        op_a = 64'(mag_r[cmd.axis]);
        op_b = 64'(mag_r[cmd.axis]);
      end
      PH_PU: begin
        op_a = 64'(mass_r);
        op_b = inv_r;
      end
      PH_U: begin
        op_a = 64'(mag_r[cmd.axis]);
        op_b = inv_r;
      end
      PH_W: begin
        op_a = 64'(u_r);
        op_b = inv_r;
      end
      PH_A: begin
        op_a = pu_r;
        op_b = w_r;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    a_half = cmd.part[0] ? op_a[63:32] : op_a[31:0];
    b_half = cmd.part[1] ? op_b[63:32] : op_b[31:0];
  end

  // square root and reciprocal steps
  assign rem_sh   = {rem_r, s_r[65:64]};
  assign trial    = {1'b0, root_r, 2'b01};
  assign rem_diff = rem_sh - trial;
  assign dnum     = {drem_r, 1'b1};
  assign ddiff    = dnum - {1'b0, root_r};

  // potential and axis terms
  assign pu_new   = prod_r[95:32];
  assign headroom = {1'b0, POT_MAX} - {1'b0, pot_r};
  assign a_big    = prod_r[127:48];
  assign a_ovf    = |a_big[79:63];

  always_comb begin
    if (!neg_r[cmd.axis]) begin
      term = a_ovf ? {1'b0, {63{1'b1}}} : $signed({1'b0, a_big[62:0]});
    end else begin
      term = a_ovf ? {1'b1, 63'd0} : -$signed({1'b0, a_big[62:0]});
    end
    sum_ext = {sum_r[cmd.axis][63], sum_r[cmd.axis]} + {term[63], term};
    if (sum_ext[64] != sum_ext[63]) begin
      sum_sat = sum_ext[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sum_sat = sum_ext[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < DSGA_AXES; k++) begin
        logic signed [32:0] dk;
        dk = $signed({in_tdata[96+32*k+31], in_tdata[96+32*k +: 32]})
           - $signed({in_tdata[32*k+31], in_tdata[32*k +: 32]});
        if (k < DIMS) begin
          neg_r[k] <= dk[32];
          mag_r[k] <= dk[32] ? 33'(-dk) : 33'(dk);
        end else begin
          neg_r[k] <= 1'b0;
          mag_r[k] <= '0;
        end
      end
      mass_r <= in_tdata[223:192];
      last_r <= in_tlast;
      s_r    <= '0;
    end
    if (cmd.mul_go) begin
      pp_r <= 64'(a_half) * 64'(b_half);
      sh_r <= 2'(cmd.part[0]) + 2'(cmd.part[1]);
    end
    if (cmd.mul_go && cmd.part == 2'd0) begin
      prod_r <= '0;
    end else if (pp_vld_r) begin
      prod_r <= prod_r + (128'(pp_r) << {sh_r, 5'd0});
    end
    if (cmd.wb) begin
      case (cmd.phase)
        PH_SQ: s_r <= s_r + prod_r[65:0];
        PH_PU: pu_r <= pu_new;
        PH_U:  u_r <= prod_r[63:32];
        PH_W:  w_r <= prod_r[95:32];
        default: ;
      endcase
    end
    if (cmd.sqrt_init) begin
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.sqrt_step) begin
      s_r <= {s_r[63:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_diff[33:0];
        root_r <= {root_r[31:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[33:0];
        root_r <= {root_r[31:0], 1'b0};
      end
    end
    if (cmd.div_init) begin
      drem_r <= '0;
      inv_r  <= '0;
    end else if (cmd.div_step) begin
      if (dnum >= {1'b0, root_r}) begin
        drem_r <= ddiff[32:0];
        inv_r  <= {inv_r[62:0], 1'b1};
      end else begin
        drem_r <= dnum[32:0];
        inv_r  <= {inv_r[62:0], 1'b0};
      end
    end
    if (cmd.emit) begin
      out_data_r <= {1'b0, pot_r, sum_r[2], sum_r[1], sum_r[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      pot_r       <= '0;
      for (int k = 0; k < DSGA_AXES; k++) sum_r[k] <= '0;
    end else begin
      pp_vld_r <= cmd.mul_go;
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (cmd.load && in_tuser) begin
        pot_r <= '0;
        for (int k = 0; k < DSGA_AXES; k++) sum_r[k] <= '0;
      end
      if (cmd.wb && cmd.phase == PH_PU) begin
        if (pu_new >= headroom) pot_r <= POT_MAX;
        else pot_r <= pot_r + pu_new[62:0];
      end
      if (cmd.wb && cmd.phase == PH_A) sum_r[cmd.axis] <= sum_sat;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign sts.s_zero   = (s_r == '0);
  assign sts.last     = last_r;
  assign sts.out_busy = out_valid_r;

endmodule

>>> hw/rtl/direct_sum_gravity_accumulator.sv
// Channel | Direction | Contents
// in_     | slave     | tdata: star_x,y,z, src_x,y,z, src_mass; tuser: first; tlast: last
// out_    | master    | tdata: acc_x, acc_y, acc_z, potential, zero pad
//
// One item at a time; in_tready is high only while the controller is idle.
// Each item works through the squared distance, the square root, the
// reciprocal and the products through the single 32x32 multiplier, with
// control states in between.
// A zero-distance source skips the root, reciprocal and products.
// A synchronous reset clears control and the sums; a held result stalls the next
// last-flagged item only until out_tready takes it.
`include "assert_macros.svh"

module direct_sum_gravity_accumulator #(
  parameter int DIMS = dsga_pkg::DSGA_DIMS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // star_x, star_y, star_z, src_x, src_y, src_z, src_mass (32 bits each)
  input  logic [223:0] in_tdata,
  // first_source
  input  logic         in_tuser,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // acc_x, acc_y, acc_z (64 bits each), potential (63 bits), one zero bit
  output logic [255:0] out_tdata
);
  import dsga_pkg::*;

  dsga_cmd_t  cmd;
  dsga_sts_t  sts;
  logic [7:0] cmd_vec;

  dsga_ctrl #(.DIMS(DIMS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dsga_datapath #(.DIMS(DIMS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

  assign cmd_vec = {cmd.load, cmd.mul_go, cmd.wb, cmd.sqrt_init, cmd.sqrt_step,
                    cmd.div_init, cmd.div_step, cmd.emit};

  `ASSERT_SAME(a_emit_free, cmd.emit, !out_tvalid, "result emitted over a held one")
  `ASSERT_NEXT(a_busy_after, in_tvalid && in_tready, !in_tready, "ready after transfer")
  `ASSERT_NEXT(a_emit_shows, cmd.emit, out_tvalid, "emitted result not shown")
  `ASSERT_SAME(a_one_cmd, 1'b1, $onehot0(cmd_vec), "overlapping commands")

endmodule
